// File: hdl/e1n_pkg.sv
// Shared constants and binary32 arithmetic functions for the expm1 datapath.
// Depends on nothing; the lane and the top module import it.
`timescale 1ns / 1ps
package e1n_pkg;

   localparam int LANES  = 4;
   // Pipeline depth of one lane: one register after each arithmetic step.
   localparam int STAGES = 18;
   localparam int HSTEPS = 8;

   localparam logic [31:0] CLAMP_FLOOR = 32'hC18AA123;
   localparam logic [31:0] MAGIC_BIAS = 32'h4B40007F;
   localparam logic [31:0] NEG_BIAS   = 32'hCB40007F;
   localparam logic [31:0] LOG2E      = 32'h3FB8AA3B;
   localparam logic [31:0] LN2_HI     = 32'hBF317220;
   localparam logic [31:0] LN2_LO     = 32'h350082E3;
   localparam logic [31:0] PC6        = 32'h3AB5B99C;
   localparam logic [31:0] PC5        = 32'h3C0913C7;
   localparam logic [31:0] PC4        = 32'h3D2AAB8B;
   localparam logic [31:0] PC3        = 32'h3E2AAA58;
   localparam logic [31:0] PC2        = 32'h3EFFFFFF;
   localparam logic [31:0] NEG_ONE    = 32'hBF800000;
   localparam logic [31:0] QNAN_BIT   = 32'h00400000;
   localparam logic [31:0] CANON_NAN  = 32'h7FC00000;

   localparam logic [31:0] HORNER_C [4] = '{PC5, PC4, PC3, PC2};

   function automatic logic is_nan(input logic [31:0] v);
      is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] v);
      is_inf = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
   endfunction

   // Leading zero count of a 51-bit word; the word is known to be nonzero.
   function automatic logic [5:0] lzc51(input logic [50:0] v);
      logic [5:0] cnt;
      cnt = 6'd51;
      for (int i = 0; i < 51; i++) begin
         if (v[i]) cnt = 6'(50 - i);
      end
      lzc51 = cnt;
   endfunction

   // Rounds to nearest even and packs. The value is m / 2^49 * 2^(bexp - 127),
   // with m[49] set for a normalized significand; stk marks lost nonzero bits.
   function automatic logic [31:0] round_pack(input logic sgn, input logic signed [12:0] bexp,
                                              input logic [49:0] m, input logic stk);
      logic signed [12:0] d;
      logic [5:0]  shamt;
      logic [49:0] lost;
      logic [49:0] mm;
      logic        st;
      logic [7:0]  ebase;
      logic [23:0] keep;
      logic        up;
      logic [31:0] res;
      if (m == 50'd0) begin
         round_pack = {sgn, 31'd0};
      end else if (bexp >= 13'sd255) begin
         round_pack = {sgn, 8'hFF, 23'd0};
      end else begin
         if (bexp <= 13'sd0) begin
            d = 13'sd1 - bexp;
            if (d > 13'sd50) d = 13'sd50;
            shamt = d[5:0];
            lost  = m & ~({50{1'b1}} << shamt);
            mm    = m >> shamt;
            st    = stk | (|lost);
            ebase = 8'd0;
         end else begin
            mm    = m;
            st    = stk;
            ebase = 8'(bexp - 13'sd1);
         end
         keep = mm[49:26];
         up   = mm[25] & ((|mm[24:0]) | st | keep[0]);
         // The hidden bit carries into the exponent field.
         res  = {1'b0, ebase, 23'd0} + {8'd0, keep} + {31'd0, up};
         round_pack = {sgn, res[30:0]};
      end
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      logic               sgn;
      logic [23:0]        ma, mb;
      logic [47:0]        prod;
      logic [5:0]         lz;
      logic [49:0]        m;
      logic signed [12:0] bexp;
      sgn = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) begin
         fmul = CANON_NAN;
      end else if (is_inf(a) || is_inf(b)) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) fmul = CANON_NAN;
         else fmul = {sgn, 8'hFF, 23'd0};
      end else if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
         fmul = {sgn, 31'd0};
      end else begin
         ma   = {|a[30:23], a[22:0]};
         mb   = {|b[30:23], b[22:0]};
         prod = ma * mb;
         lz   = lzc51({prod, 3'd0});
         m    = {prod, 2'd0} << lz;
         bexp = 13'(a[30:23] == 8'd0 ? 8'd1 : a[30:23])
              + 13'(b[30:23] == 8'd0 ? 8'd1 : b[30:23])
              - 13'sd126 - 13'(lz);
         fmul = round_pack(sgn, bexp, m, 1'b0);
      end
   endfunction

   function automatic logic [31:0] fadd(input logic [31:0] a0, input logic [31:0] b0);
      logic [31:0]        a, b;
      logic [7:0]         ea, eb, d8;
      logic [5:0]         dd;
      logic [50:0]        am, bf, lost, bs, sum;
      logic [5:0]         lz;
      logic [50:0]        mm;
      logic signed [12:0] bexp;
      if (is_nan(a0) || is_nan(b0)) begin
         fadd = CANON_NAN;
      end else if (is_inf(a0) && is_inf(b0) && (a0[31] != b0[31])) begin
         fadd = CANON_NAN;
      end else if (is_inf(a0)) begin
         fadd = a0;
      end else if (is_inf(b0)) begin
         fadd = b0;
      end else begin
         if (b0[30:0] > a0[30:0]) begin
            a = b0;
            b = a0;
         end else begin
            a = a0;
            b = b0;
         end
         ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
         eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
         d8   = ea - eb;
         dd   = (d8 > 8'd63) ? 6'd63 : d8[5:0];
         am   = {1'b0, |a[30:23], a[22:0], 26'd0};
         bf   = {1'b0, |b[30:23], b[22:0], 26'd0};
         lost = bf & ~({51{1'b1}} << dd);
         bs   = (bf >> dd) | {50'd0, |lost};
         sum  = (a[31] ^ b[31]) ? (am - bs) : (am + bs);
         if (sum == 51'd0) begin
            fadd = {a[31] & b[31], 31'd0};
         end else begin
            lz   = lzc51(sum);
            mm   = sum << lz;
            bexp = 13'(ea) + 13'sd1 - 13'(lz);
            fadd = round_pack(a[31], bexp, mm[50:1], mm[0]);
         end
      end
   endfunction

endpackage

// File: hdl/e1n_lane.sv
// One expm1 lane: an 18-stage pipeline, one rounded binary32 operation per step.
// Depends on e1n_pkg for the constants and the multiply and add functions.
`timescale 1ns / 1ps
module e1n_lane
   import e1n_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] x,
   output logic [31:0] y
);

   logic [31:0] xc;
   logic [31:0] nanv_ff [STAGES-1];
   logic        nan_ff  [STAGES-1];

   logic [31:0] m1_ff, x0_ff;
   logic [31:0] n_ff, x1_ff;
   logic [31:0] n2_ff, s2_ff, x2_ff;
   logic [31:0] a_ff, b3_ff, s3_ff, x3_ff;
   logic [31:0] t4_ff, b4_ff, s4_ff;
   logic [31:0] t5_ff, s5_ff;
   logic [31:0] p6_ff, t6_ff, ts6_ff, sm6_ff;
   logic [31:0] p_ff [HSTEPS];
   logic [31:0] t_ff [HSTEPS];
   logic [31:0] ts_ff [HSTEPS];
   logic [31:0] sm_ff [HSTEPS];
   logic [31:0] q15_ff, ts15_ff, sm15_ff;
   logic [31:0] q16_ff, sm16_ff;
   logic [31:0] f_in, y_ff;

   // Clamp from below; a negative NaN is clamped too, and every NaN is handled on its own path.
   assign xc = (x[31] && (x[30:0] > CLAMP_FLOOR[30:0])) ? CLAMP_FLOOR : x;

   always_ff @(posedge clock) begin
      if (en) begin
         nan_ff[0]  <= is_nan(x);
         nanv_ff[0] <= x | QNAN_BIT;
         for (int i = 1; i < STAGES - 1; i++) begin
            nan_ff[i]  <= nan_ff[i-1];
            nanv_ff[i] <= nanv_ff[i-1];
         end
         m1_ff  <= fmul(xc, LOG2E);
         x0_ff  <= xc;
         n_ff   <= fadd(m1_ff, MAGIC_BIAS);
         x1_ff  <= x0_ff;
         // The scale 2^n comes from the low bits of the biased sum.
         s2_ff  <= {n_ff[8:0], 23'd0};
         n2_ff  <= fadd(n_ff, NEG_BIAS);
         x2_ff  <= x1_ff;
         a_ff   <= fmul(n2_ff, LN2_HI);
         b3_ff  <= fmul(n2_ff, LN2_LO);
         s3_ff  <= s2_ff;
         x3_ff  <= x2_ff;
         t4_ff  <= fadd(a_ff, x3_ff);
         b4_ff  <= b3_ff;
         s4_ff  <= s3_ff;
         t5_ff  <= fadd(b4_ff, t4_ff);
         s5_ff  <= s4_ff;
         p6_ff  <= fmul(PC6, t5_ff);
         ts6_ff <= fmul(t5_ff, s5_ff);
         sm6_ff <= fadd(s5_ff, NEG_ONE);
         t6_ff  <= t5_ff;
      end
   end

   // Horner steps: even steps add the next coefficient, odd steps multiply by t.
   for (genvar k = 0; k < HSTEPS; k++) begin : g_horner
      logic [31:0] p_prev, t_prev, ts_prev, sm_prev;
      if (k == 0) begin : g_first
         assign p_prev  = p6_ff;
         assign t_prev  = t6_ff;
         assign ts_prev = ts6_ff;
         assign sm_prev = sm6_ff;
      end else begin : g_next
         assign p_prev  = p_ff[k-1];
         assign t_prev  = t_ff[k-1];
         assign ts_prev = ts_ff[k-1];
         assign sm_prev = sm_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if ((k % 2) == 0) p_ff[k] <= fadd(p_prev, HORNER_C[k/2]);
            else p_ff[k] <= fmul(p_prev, t_prev);
            t_ff[k]  <= t_prev;
            ts_ff[k] <= ts_prev;
            sm_ff[k] <= sm_prev;
         end
      end
   end

   always_comb begin
      f_in = fadd(q16_ff, sm16_ff);
      if (nan_ff[STAGES-2]) f_in = nanv_ff[STAGES-2];
      else if (is_nan(f_in)) f_in = CANON_NAN;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q15_ff  <= fmul(p_ff[HSTEPS-1], ts_ff[HSTEPS-1]);
         ts15_ff <= ts_ff[HSTEPS-1];
         sm15_ff <= sm_ff[HSTEPS-1];
         q16_ff  <= fadd(q15_ff, ts15_ff);
         sm16_ff <= sm15_ff;
         y_ff    <= f_in;
      end
   end

   assign y = y_ff;

endmodule

// File: hdl/expm1_negative_f32_poly.sv
// expm1 over four binary32 lanes per word, with the stall and valid flow control.
// Depends on e1n_pkg and e1n_lane.
`timescale 1ns / 1ps
// A word enters every cycle unless the pipeline is halted; the depth is
// set by the 18 rounded multiply and add steps of each lane, each one registered.
// All lanes and the last-group flag move as one pipeline that halts only while a
// finished word waits at the output under rsp_stall. There is no state to reset
// beyond the valid bits.
module expm1_negative_f32_poly
   import e1n_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_x_lane0,
   input  logic [31:0] req_x_lane1,
   input  logic [31:0] req_x_lane2,
   input  logic [31:0] req_x_lane3,
   input  logic        req_last_group,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_y_lane0,
   output logic [31:0] rsp_y_lane1,
   output logic [31:0] rsp_y_lane2,
   output logic [31:0] rsp_y_lane3,
   output logic        rsp_last_group_out
);

   logic        adv;
   logic [31:0] x_lane [LANES];
   logic [31:0] y_lane [LANES];
   logic        vld_ff  [STAGES];
   logic        last_ff [STAGES];

   assign x_lane[0] = req_x_lane0;
   assign x_lane[1] = req_x_lane1;
   assign x_lane[2] = req_x_lane2;
   assign x_lane[3] = req_x_lane3;

   // The whole pipeline steps unless the output word is held.
   assign adv       = !(vld_ff[STAGES-1] && rsp_stall);
   assign req_stall = !adv;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      e1n_lane u_lane (
         .clock (clock),
         .en    (adv),
         .x     (x_lane[l]),
         .y     (y_lane[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < STAGES; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff[0] <= req_last_group;
         for (int i = 1; i < STAGES; i++) last_ff[i] <= last_ff[i-1];
      end
   end

   assign rsp_valid          = vld_ff[STAGES-1];
   assign rsp_last_group_out = last_ff[STAGES-1];
   assign rsp_y_lane0        = y_lane[0];
   assign rsp_y_lane1        = y_lane[1];
   assign rsp_y_lane2        = y_lane[2];
   assign rsp_y_lane3        = y_lane[3];

endmodule

// File: sim/tb_expm1_negative_f32_poly.sv
// Self-checking testbench for expm1_negative_f32_poly: four binary32 lanes per word.
// It predicts every result with its own binary32 arithmetic and needs only the RTL.
`timescale 1ns / 1ps
module tb_expm1_negative_f32_poly;

   localparam logic [31:0] CLAMP_LOW   = 32'hC18AA123;
   localparam logic [31:0] ROUND_BIAS  = 32'h4B40007F;
   localparam logic [31:0] ROUND_UNB   = 32'hCB40007F;
   localparam logic [31:0] K_LOG2E     = 32'h3FB8AA3B;
   localparam logic [31:0] K_LN2_HI    = 32'hBF317220;
   localparam logic [31:0] K_LN2_LO    = 32'h350082E3;
   localparam logic [31:0] K_C6        = 32'h3AB5B99C;
   localparam logic [31:0] K_C5        = 32'h3C0913C7;
   localparam logic [31:0] K_C4        = 32'h3D2AAB8B;
   localparam logic [31:0] K_C3        = 32'h3E2AAA58;
   localparam logic [31:0] K_C2        = 32'h3EFFFFFF;
   localparam logic [31:0] K_MINUS_ONE = 32'hBF800000;
   localparam logic [31:0] QUIET_BIT   = 32'h00400000;
   localparam logic [31:0] DEFAULT_NAN = 32'h7FC00000;
   localparam int          STALL_LIMIT = 5000;
   localparam int          DRAIN_WAIT  = 40;

   typedef struct {
      logic [31:0] y [4];
      logic        last;
   } group_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_x [4] = '{32'd0, 32'd0, 32'd0, 32'd0};
   logic        req_last_group = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_y [4];
   logic        rsp_last_group_out;

   group_result_type expected_groups [$];
   int  error_count = 0;
   bit  idling_on = 1'b1;
   bit  hold_request = 1'b0;
   int  quiet_cycles = 0;

   always #1 clock = ~clock;

   expm1_negative_f32_poly dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_x_lane0        (req_x[0]),
      .req_x_lane1        (req_x[1]),
      .req_x_lane2        (req_x[2]),
      .req_x_lane3        (req_x[3]),
      .req_last_group     (req_last_group),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_y_lane0        (rsp_y[0]),
      .rsp_y_lane1        (rsp_y[1]),
      .rsp_y_lane2        (rsp_y[2]),
      .rsp_y_lane3        (rsp_y[3]),
      .rsp_last_group_out (rsp_last_group_out)
   );

   // ---------------- binary32 arithmetic through double precision ----------------
   // A product of two singles is exact in double, and a sum rounded first to double
   // and then to single still rounds correctly, since 53 >= 2*24+2.

   function automatic logic f32_is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic f32_is_inf(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
   endfunction

   function automatic real f32_value(input logic [31:0] v);
      real mag;
      int  ex;
      ex  = (v[30:23] == 8'd0) ? 1 : int'(v[30:23]);
      mag = real'({v[30:23] != 8'd0, v[22:0]}) * (2.0 ** (ex - 150));
      return v[31] ? -mag : mag;
   endfunction

   function automatic logic [31:0] round_to_f32(input real r);
      logic [63:0] d;
      logic [63:0] sig, kept, rem, half;
      logic [31:0] res;
      logic        up;
      int          be, sh;
      d = $realtobits(r);
      if (d[62:0] == 63'd0) return {d[63], 31'd0};
      if (d[62:52] == 11'h7FF) return (d[51:0] != 52'd0) ? DEFAULT_NAN : {d[63], 8'hFF, 23'd0};
      be = int'(d[62:52]) - 1023 + 127;
      if (be >= 255) return {d[63], 8'hFF, 23'd0};
      sig  = {11'd0, 1'b1, d[51:0]};
      sh   = (be >= 1) ? 29 : 30 - be;
      if (sh > 62) sh = 62;
      kept = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      up   = (rem > half) || (rem == half && kept[0]);
      // The hidden bit carries into the exponent field; a carry out of the top
      // of the significand lands exactly on infinity.
      res  = ((be >= 1) ? (32'(be - 1) << 23) : 32'd0) + kept[31:0] + 32'(up);
      return {d[63], res[30:0]};
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
      if (f32_is_nan(a) || f32_is_nan(b)) return DEFAULT_NAN;
      if (f32_is_inf(a) || f32_is_inf(b)) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return DEFAULT_NAN;
         return {a[31] ^ b[31], 8'hFF, 23'd0};
      end
      return round_to_f32(f32_value(a) * f32_value(b));
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
      if (f32_is_nan(a) || f32_is_nan(b)) return DEFAULT_NAN;
      if (f32_is_inf(a) && f32_is_inf(b) && a[31] != b[31]) return DEFAULT_NAN;
      if (f32_is_inf(a)) return a;
      if (f32_is_inf(b)) return b;
      return round_to_f32(f32_value(a) + f32_value(b));
   endfunction

   function automatic logic [31:0] expm1_of(input logic [31:0] x_in);
      logic [31:0] x, n, s, t, p, ts, sm1, f;
      if (f32_is_nan(x_in)) return x_in | QUIET_BIT;
      x = x_in;
      // Anything more negative than the clamp point, minus infinity too, is clamped.
      if (x[31] && x[30:0] > CLAMP_LOW[30:0]) x = CLAMP_LOW;
      n   = f32_add(f32_mul(x, K_LOG2E), ROUND_BIAS);
      s   = n << 23;
      n   = f32_add(n, ROUND_UNB);
      t   = f32_add(f32_mul(n, K_LN2_HI), x);
      t   = f32_add(f32_mul(n, K_LN2_LO), t);
      p   = f32_add(f32_mul(K_C6, t), K_C5);
      p   = f32_add(f32_mul(p, t), K_C4);
      p   = f32_add(f32_mul(p, t), K_C3);
      p   = f32_add(f32_mul(p, t), K_C2);
      p   = f32_mul(p, t);
      ts  = f32_mul(t, s);
      sm1 = f32_add(s, K_MINUS_ONE);
      p   = f32_add(f32_mul(p, ts), ts);
      f   = f32_add(p, sm1);
      return f32_is_nan(f) ? DEFAULT_NAN : f;
   endfunction

   // ---------------- sender ----------------

   task automatic send_word(input logic [31:0] x0, input logic [31:0] x1,
                            input logic [31:0] x2, input logic [31:0] x3, input logic last);
      group_result_type g;
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(negedge clock);
      end
      req_x[0] = x0;
      req_x[1] = x1;
      req_x[2] = x2;
      req_x[3] = x3;
      req_last_group = last;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      for (int i = 0; i < 4; i++) g.y[i] = expm1_of(req_x[i]);
      g.last = last;
      expected_groups.push_back(g);
      @(negedge clock);
   endtask

   // Biased toward the range (-32, 0), which covers the clamp point, with full random bits mixed in.
   function automatic logic [31:0] pick_x();
      unique case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return {1'b1, 8'($urandom_range(100, 131)), 23'($urandom)};
         5: return {1'b0, 8'($urandom_range(100, 134)), 23'($urandom)};
         6: return {1'b1, 8'($urandom_range(0, 99)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_words(input int count);
      for (int k = 0; k < count; k++)
         send_word(pick_x(), pick_x(), pick_x(), pick_x(), 1'($urandom_range(0, 1)));
   endtask

   // ---------------- tests ----------------

   task automatic test_special_values();
      send_word(32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 1'b0);
      send_word(32'h7FC00000, 32'h7F800001, 32'hFFBFFFFF, 32'hFFFFFFFF, 1'b1);
      send_word(32'h00000001, 32'h80000001, 32'h007FFFFF, 32'h807FFFFF, 1'b0);
      send_word(32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00800000, 32'h80800000, 1'b1);
      send_word(32'h3F800000, 32'hBF800000, 32'h42B00000, 32'h43000000, 1'b0);
   endtask

   task automatic test_clamp_edge();
      send_word(CLAMP_LOW, CLAMP_LOW + 32'd1, CLAMP_LOW - 32'd1, 32'hC1A00000, 1'b0);
      send_word(32'hBF317218, 32'hBE800000, 32'hC0000000, 32'hC1000000, 1'b1);
      send_word(32'hB3800000, 32'h33800000, 32'hC1900000, 32'hC2000000, 1'b0);
      send_word(32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFE, 32'h7FFFFFFF, 1'b1);
   endtask

   task automatic test_random_groups();
      send_random_words(900);
   endtask

   task automatic test_backpressure_fill();
      hold_request = 1'b1;
      send_random_words(80);
   endtask

   task automatic test_full_rate();
      idling_on = 1'b0;
      send_random_words(250);
   endtask

   // ---------------- receiver stall ----------------

   initial begin
      int len;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall = 1'b1;
            for (int c = 0; c < 80; c++) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, 10);
            rsp_stall = 1'b1;
            repeat (len) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // ---------------- result check ----------------

   always @(posedge clock) begin
      group_result_type g;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_groups.size() == 0) begin
            $error("unexpected result word");
            error_count++;
         end else begin
            g = expected_groups.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (rsp_y[i] !== g.y[i]) begin
                  $error("y_lane%0d expected %h actual %h", i, g.y[i], rsp_y[i]);
                  error_count++;
               end
            end
            if (rsp_last_group_out !== g.last) begin
               $error("last_group_out expected %b actual %b", g.last, rsp_last_group_out);
               error_count++;
            end
         end
      end
   end

   // The watchdog restarts whenever either side moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_special_values();
      test_clamp_edge();
      test_random_groups();
      test_backpressure_fill();
      test_full_rate();
      req_valid = 1'b0;
      wait (expected_groups.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
